>>> rtl/core/rbp_pkg.sv
// Shared types and codes for the reference-counted buffer pool.
// Holds command/result transaction structs, action/status codes and sequencer states.
// No dependencies.
`default_nettype none

package rbp_pkg;

    // Field widths fixed by the command and result formats
    localparam int SLOT_FIELD_W  = 4;
    localparam int COUNT_FIELD_W = 4;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_SET     = 2'd1,
        ACT_RELEASE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_DOUBLE    = 2'd2
    } status_t;

    typedef struct packed {
        action_t                  action;
        logic [SLOT_FIELD_W-1:0]  slot_index;
        logic [COUNT_FIELD_W-1:0] new_count;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] granted_slot;
        status_t                 status;
    } result_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_RELEASE_CHK,
        SEQ_DONE
    } seq_state_t;

endpackage

`default_nettype wire

>>> rtl/core/rbp_slot_store.sv
// Reference count storage for the buffer pool: one write port, one registered read port.
// Per-slot valid flops make never-written slots read as zero after reset.
// No package dependencies.
`default_nettype none

module rbp_slot_store #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4,
    parameter int CNT_W = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic      [CNT_W-1:0] rd_count,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [CNT_W-1:0] wr_count
);

    logic [CNT_W-1:0] count_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [CNT_W-1:0] rd_data_reg;
    logic             rd_valid_reg;

    // Write the count array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            count_mem[wr_addr] <= wr_count;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        rd_data_reg <= count_mem[rd_addr];
    end

    // Mark written slots; reset frees every slot at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Unwritten slots read as free
    assign rd_count = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> rtl/core/refcounted_buffer_pool.sv
// Top level of the reference-counted buffer pool allocator.
// Depends on rbp_pkg (types, codes) and rbp_slot_store (count memory).
//
// Channel   Ports                 Handshake
// -------   -------------------   ------------------------------------------
// command   start, busy, cmd      taken at a clock edge with start=1, busy=0
// result    done, result          valid for one cycle while done=1, no stall
//
// Allocate scans the slots upward from slot 0 and grants the first free one; an
// exhausted pool reports ST_EXHAUSTED after the last slot. Set-references writes
// at accept; release reads the slot, then checks it (skipped when out of range).
// The scan costs one slot per cycle through the single read port of the count
// memory and one zero compare. The pool goes idle before the next accept.
// Reset frees all slots at once through per-slot valid flops; no clearing pass.
// busy stays high from accept through the result cycle; results cannot stall.
`default_nettype none

module refcounted_buffer_pool #(
    parameter int POOL_SLOTS = 16,
    parameter int MAX_REFS   = 15
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire rbp_pkg::cmd_t   cmd,
    output logic                 done,
    output rbp_pkg::result_t     result
);

    import rbp_pkg::*;

    localparam int IDX_W = $clog2(POOL_SLOTS);
    localparam int CNT_W = $clog2(MAX_REFS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);

    seq_state_t       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    result_t          result_reg, result_next;

    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] rd_count;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_count;

    logic             in_range_new, in_range_held;
    logic [IDX_W-1:0] addr_new, addr_held;
    logic [CNT_W-1:0] sat_count;
    logic             count_zero;
    logic [CNT_W-1:0] count_dec;

    rbp_slot_store #(
        .DEPTH (POOL_SLOTS),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .rd_count (rd_count),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_count (wr_count)
    );

    // Decode slot addresses and clamp the requested count
    assign in_range_new  = (32'(cmd.slot_index) < POOL_SLOTS);
    assign in_range_held = (32'(cmd_reg.slot_index) < POOL_SLOTS);
    assign addr_new      = IDX_W'(cmd.slot_index);
    assign addr_held     = IDX_W'(cmd_reg.slot_index);
    assign sat_count     = (32'(cmd.new_count) > MAX_REFS) ? CNT_W'(MAX_REFS)
                                                           : CNT_W'(cmd.new_count);

    // Shared count unit: zero test and decrement of the word just read
    assign count_zero = (rd_count == '0);
    assign count_dec  = rd_count - CNT_W'(1);

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the transaction and its result
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        chk_idx_reg <= chk_idx_next;
        result_reg  <= result_next;
    end

    // Sequence each command through scan (allocate) or check (release), then report
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        chk_idx_next = chk_idx_reg;
        result_next  = result_reg;
        rd_addr      = chk_idx_reg;
        wr_en        = 1'b0;
        wr_addr      = addr_held;
        wr_count     = count_dec;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    cmd_next                 = cmd;
                    result_next.granted_slot = cmd.slot_index;
                    result_next.status       = ST_OK;
                    state_next               = SEQ_DONE;
                    case (cmd.action)
                        ACT_ALLOC:
                        begin
                            rd_addr      = '0;
                            chk_idx_next = '0;
                            state_next   = SEQ_SCAN;
                        end
                        ACT_SET:
                        begin
                            if (in_range_new)
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = addr_new;
                                wr_count = sat_count;
                            end
                        end
                        ACT_RELEASE:
                        begin
                            if (in_range_new)
                            begin
                                rd_addr    = addr_new;
                                state_next = SEQ_RELEASE_CHK;
                            end
                        end
                        default:
                        begin
                            // unused action code: echo and report ok
                        end
                    endcase
                end
            end

            SEQ_SCAN:
            begin
                if (count_zero)
                begin
                    wr_en                    = 1'b1;
                    wr_addr                  = chk_idx_reg;
                    wr_count                 = CNT_W'(1);
                    result_next.granted_slot = SLOT_FIELD_W'(chk_idx_reg);
                    result_next.status       = ST_OK;
                    state_next               = SEQ_DONE;
                end
                else if (chk_idx_reg == LAST_IDX)
                begin
                    result_next.granted_slot = '0;
                    result_next.status       = ST_EXHAUSTED;
                    state_next               = SEQ_DONE;
                end
                else
                begin
                    // advance to the next slot
                    rd_addr      = chk_idx_reg + IDX_W'(1);
                    chk_idx_next = chk_idx_reg + IDX_W'(1);
                end
            end

            SEQ_RELEASE_CHK:
            begin
                if (count_zero)
                begin
                    result_next.status = ST_DOUBLE;
                end
                else
                begin
                    wr_en    = in_range_held;
                    wr_count = count_dec;
                end
                state_next = SEQ_DONE;
            end

            SEQ_DONE:
            begin
                state_next = SEQ_IDLE;
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != SEQ_IDLE);
    assign done   = (state_reg == SEQ_DONE);
    assign result = result_reg;

    // A result only appears while a command is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe without a command in flight");

    // An accepted command always blocks the next one
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");

    // Exactly one result per command, then ready again
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe not followed by idle");

    // Exhausted pool reports slot zero
    a_exhausted_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_EXHAUSTED) |-> (result.granted_slot == '0))
        else $error("exhausted result with nonzero slot");

endmodule

`default_nettype wire
